// ===== rtl/signed_int_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text block
// Each check can be compiled out by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is asserted.
`define SID_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, also active during reset.
`define SID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SID_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SID_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg
// Widths, character codes and status types shared by the decimal text block.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int VALUE_W    = 32;
    // Decimal digits needed for any 32-bit magnitude.
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * 4;
    // Size of the digit buffer; higher digits beyond it are dropped.
    localparam int MAX_DIGITS = 10;
    localparam int EMIT_DIGITS = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
    localparam int IDX_W      = $clog2(BCD_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_W);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

endpackage

// ===== rtl/sid_dabble.sv =====
// ----------------------------------------------------------------------------
// sid_dabble
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module sid_dabble (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sid_pkg::VALUE_W-1:0] mag,
    output sid_pkg::dab_status_t       status,
    output logic [sid_pkg::BCD_W-1:0]  bcd
);

    logic [sid_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [sid_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [sid_pkg::BCD_W-1:0]   adj;
    logic [sid_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    localparam logic [sid_pkg::CNT_W-1:0] CNT_LAST = sid_pkg::CNT_W'(sid_pkg::VALUE_W - 1);

    // Every digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < sid_pkg::BCD_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj[sid_pkg::BCD_W-2:0], bin_reg[sid_pkg::VALUE_W-1]};
            bin_next = {bin_reg[sid_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints a signed 32-bit integer as decimal ASCII text, one character per
// output request, most significant digit first.
// ----------------------------------------------------------------------------
//  Channel  Dir  Ports                          Request
//  s_       in   s_valid s_ready s_value        one signed integer
//  m_       out  m_valid m_ready m_character    one character, m_last on final
//                m_last
//
// An integer is accepted, converted in the shift-and-add-3 BCD unit, its
// leading digit found as the conversion finishes, then printed one character
// per cycle (up to 11) while the output is not stalled.
// s_ready is high only while the sequencer is idle; the final character may
// still wait in the output register while the next integer is taken.
// A stalled output holds the sequencer in its emit state. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [sid_pkg::VALUE_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_character,
    output logic                        m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    localparam logic [sid_pkg::IDX_W-1:0] EMIT_TOP = sid_pkg::IDX_W'(sid_pkg::EMIT_DIGITS - 1);

    state_t                      state_reg, state_next;
    logic                        neg_reg, neg_next;
    logic                        sign_reg, sign_next;
    logic [sid_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  char_reg, char_next;
    logic                        last_reg, last_next;

    logic                        accept;
    logic                        start;
    logic [sid_pkg::VALUE_W-1:0] mag;
    sid_pkg::dab_status_t        dab_stat;
    logic [sid_pkg::BCD_W-1:0]   bcd;
    logic [sid_pkg::IDX_W-1:0]   top_idx;
    logic [3:0]                  digit;
    logic                        load;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign start   = accept;
    // Two's complement negation in unsigned arithmetic covers the most negative value.
    assign mag     = s_value[sid_pkg::VALUE_W-1] ? (32'd0 - s_value) : s_value;

    sid_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .mag     (mag),
        .status  (dab_stat),
        .bcd     (bcd)
    );

    // Highest nonzero digit, clamped to the digit buffer size.
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < sid_pkg::BCD_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                top_idx = sid_pkg::IDX_W'(i);
            end
        end
        if (top_idx > EMIT_TOP) begin
            top_idx = EMIT_TOP;
        end
    end

    assign digit = bcd[idx_reg*4 +: 4];
    assign load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        sign_next    = sign_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = s_value[sid_pkg::VALUE_W-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (dab_stat.done) begin
                    idx_next   = top_idx;
                    sign_next  = neg_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    if (sign_reg) begin
                        char_next = sid_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end else begin
                        char_next = sid_pkg::CHAR_ZERO + {4'd0, digit};
                        last_next = (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            sign_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            sign_reg    <= sign_next;
        end
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

    `SID_ASSERT_CLK(a_idle_not_busy, aclk, aresetn, s_ready |-> !dab_stat.busy,
        "ready while converting")
    `SID_ASSERT_CLK(a_start_busy, aclk, aresetn, accept |=> dab_stat.busy,
        "conversion did not start")
    `SID_ASSERT_CLK(a_sign_not_last, aclk, aresetn,
        (m_valid && m_character == sid_pkg::CHAR_MINUS) |-> !m_last,
        "minus sign flagged last")
    `SID_ASSERT_CLK(a_digit_range, aclk, aresetn,
        (m_valid && m_character != sid_pkg::CHAR_MINUS) |->
            (m_character >= sid_pkg::CHAR_ZERO && m_character <= sid_pkg::CHAR_ZERO + 8'd9),
        "character is not a digit")
    `SID_ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> (state_reg == ST_IDLE && !m_valid_reg),
        "reset did not clear control")

endmodule
